### rtl/c2dzp_pkg.sv
package c2dzp_pkg;

    localparam int MAX_IMAGE  = 64;
    localparam int MAX_KERNEL = 8;

    localparam int KDEPTH  = MAX_KERNEL * MAX_KERNEL;
    localparam int IDEPTH  = MAX_IMAGE * MAX_IMAGE;
    localparam int KADDR_W = $clog2(KDEPTH);
    localparam int IADDR_W = $clog2(IDEPTH);
    localparam int KCNT_W  = $clog2(MAX_KERNEL + 1);

    // operation codes
    localparam logic [1:0] OP_LOAD_KERNEL = 2'd0;
    localparam logic [1:0] OP_LOAD_PIXEL  = 2'd1;
    localparam logic [1:0] OP_EMIT        = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_IMAGE_SIZE  = 2'd0;
    localparam logic [1:0] CFG_KERNEL_SIZE = 2'd1;
    localparam logic [1:0] CFG_PAD_WIDTH   = 2'd2;

    localparam logic [6:0] IMAGE_SIZE_RST  = 7'd28;
    localparam logic [3:0] KERNEL_SIZE_RST = 4'd3;
    localparam logic [2:0] PAD_WIDTH_RST   = 3'd0;

    typedef struct packed {
        logic [1:0]          op;
        logic signed [15:0]  sample;
    } in_item_t;

    typedef struct packed {
        logic signed [37:0]  conv_value;
        logic [6:0]          out_row;
        logic [6:0]          out_col;
        logic                last;
        logic                bad_geometry;
    } out_item_t;

    typedef struct packed {
        logic kload;
        logic pload;
        logic start;
        logic setup;
        logic step;
        logic publish;
    } dp_cmd_t;

    typedef struct packed {
        logic bad;
        logic last_step;
        logic pipe_empty;
    } dp_status_t;

endpackage

### rtl/c2dzp_ctrl.sv
module c2dzp_ctrl
    import c2dzp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] in_op,
    output logic       out_valid,
    input  logic       out_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kload  = accept && (in_op == OP_LOAD_KERNEL);
        cmd.pload  = accept && (in_op == OP_LOAD_PIXEL);
        cmd.start  = accept && (in_op == OP_EMIT);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = status.bad ? ST_DONE : ST_RUN;
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/c2dzp_dp.sv
module c2dzp_dp
    import c2dzp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic signed [15:0] sample,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    output out_item_t          out_data
);

    // configuration
    logic [6:0] image_size_reg;
    logic [3:0] kernel_size_reg;
    logic [2:0] pad_width_reg;
    logic       cfg_hit;

    // load indexes and output cursor
    logic [KADDR_W-1:0] kidx_reg;
    logic [KADDR_W-1:0] kidx_next;
    logic [IADDR_W-1:0] pidx_reg;
    logic [IADDR_W-1:0] pidx_next;
    logic [6:0]         cur_row_reg;
    logic [6:0]         cur_col_reg;

    // stores
    logic [15:0] kernel_mem [KDEPTH];
    logic [15:0] image_mem  [IDEPTH];

    // geometry
    logic [7:0]  kk;
    logic [13:0] nn;
    logic [7:0]  psize;
    logic [7:0]  osize;
    logic        bad_now;
    logic [KADDR_W:0] kidx_inc;
    logic [IADDR_W:0] pidx_inc;

    // window walk
    logic               bad_reg;
    logic [7:0]         osize_reg;
    logic [6:0]         r_reg;
    logic [6:0]         c_reg;
    logic [KCNT_W-1:0]  a_reg;
    logic [KCNT_W-1:0]  b_reg;
    logic signed [7:0]  ir_reg;
    logic signed [7:0]  ic_reg;
    logic signed [7:0]  ic0;
    logic signed [7:0]  ir0;
    logic signed [7:0]  n_s;
    logic signed [15:0] row_base_reg;
    logic signed [15:0] pix_addr;
    logic [KADDR_W-1:0] kaddr_reg;
    logic               row_end;
    logic               inb;

    // multiply-accumulate pipeline
    logic               v1_reg;
    logic               v2_reg;
    logic               inb1_reg;
    logic signed [15:0] coef_reg;
    logic signed [15:0] pix_reg;
    logic signed [31:0] prod_reg;
    logic signed [37:0] acc_reg;
    logic               is_last;

    assign kk    = 8'(kernel_size_reg * kernel_size_reg);
    assign nn    = 14'(image_size_reg * image_size_reg);
    assign psize = {1'b0, image_size_reg} + {4'b0, pad_width_reg, 1'b0};
    assign osize = psize - {4'b0, kernel_size_reg} + 8'd1;
    assign bad_now = (image_size_reg == 7'd0) || (image_size_reg > 7'(MAX_IMAGE))
                   || (kernel_size_reg == 4'd0) || (kernel_size_reg > 4'(MAX_KERNEL))
                   || (psize < {4'b0, kernel_size_reg});

    assign kidx_inc  = {1'b0, kidx_reg} + (KADDR_W+1)'(1);
    assign kidx_next = ((8'(kidx_inc) >= kk) || (kidx_inc >= (KADDR_W+1)'(KDEPTH)))
                     ? '0 : kidx_inc[KADDR_W-1:0];
    assign pidx_inc  = {1'b0, pidx_reg} + (IADDR_W+1)'(1);
    assign pidx_next = ((14'(pidx_inc) >= nn) || (pidx_inc >= (IADDR_W+1)'(IDEPTH)))
                     ? '0 : pidx_inc[IADDR_W-1:0];

    assign cfg_hit = cfg_we && ((cfg_index == CFG_IMAGE_SIZE)
                   || (cfg_index == CFG_KERNEL_SIZE) || (cfg_index == CFG_PAD_WIDTH));

    assign n_s = $signed({1'b0, image_size_reg});
    assign ir0 = $signed({1'b0, r_reg}) - $signed({5'b0, pad_width_reg});
    assign ic0 = $signed({1'b0, c_reg}) - $signed({5'b0, pad_width_reg});

    assign row_end  = (b_reg == KCNT_W'(kernel_size_reg - 4'd1));
    assign inb      = (ir_reg >= 0) && (ir_reg < n_s) && (ic_reg >= 0) && (ic_reg < n_s);
    assign pix_addr = row_base_reg + 16'(ic_reg);
    assign is_last  = ({1'b0, r_reg} == osize_reg - 8'd1)
                    && ({1'b0, c_reg} == osize_reg - 8'd1);

    assign status.bad        = bad_reg;
    assign status.last_step  = row_end && (a_reg == KCNT_W'(kernel_size_reg - 4'd1));
    assign status.pipe_empty = !v1_reg && !v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg  <= IMAGE_SIZE_RST;
            kernel_size_reg <= KERNEL_SIZE_RST;
            pad_width_reg   <= PAD_WIDTH_RST;
            kidx_reg        <= '0;
            pidx_reg        <= '0;
            cur_row_reg     <= '0;
            cur_col_reg     <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.step;
            v2_reg <= v1_reg;
            if (cfg_hit)
            begin
                unique case (cfg_index)
                    CFG_IMAGE_SIZE:  image_size_reg  <= cfg_data;
                    CFG_KERNEL_SIZE: kernel_size_reg <= cfg_data[3:0];
                    CFG_PAD_WIDTH:   pad_width_reg   <= cfg_data[2:0];
                    default:         image_size_reg  <= image_size_reg;
                endcase
                kidx_reg    <= '0;
                pidx_reg    <= '0;
                cur_row_reg <= '0;
                cur_col_reg <= '0;
            end
            else
            begin
                if (cmd.kload)
                begin
                    kidx_reg <= kidx_next;
                end
                if (cmd.pload)
                begin
                    pidx_reg <= pidx_next;
                end
                if (cmd.publish && !bad_reg)
                begin
                    if ({1'b0, c_reg} + 8'd1 < osize_reg)
                    begin
                        cur_col_reg <= c_reg + 7'd1;
                        cur_row_reg <= r_reg;
                    end
                    else
                    begin
                        cur_col_reg <= '0;
                        cur_row_reg <= ({1'b0, r_reg} + 8'd1 < osize_reg) ? r_reg + 7'd1 : '0;
                    end
                end
            end
        end
    end

    // stores with registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.kload)
        begin
            kernel_mem[kidx_reg] <= sample;
        end
        if (cmd.pload)
        begin
            image_mem[pidx_reg] <= sample;
        end
        coef_reg <= $signed(kernel_mem[kaddr_reg]);
        pix_reg  <= $signed(image_mem[pix_addr[IADDR_W-1:0]]);
    end

    // window walk, multiply and accumulate
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            bad_reg   <= bad_now;
            osize_reg <= osize;
            // out-of-range cursor restarts at the origin
            if (({1'b0, cur_row_reg} >= osize) || ({1'b0, cur_col_reg} >= osize))
            begin
                r_reg <= '0;
                c_reg <= '0;
            end
            else
            begin
                r_reg <= cur_row_reg;
                c_reg <= cur_col_reg;
            end
        end
        if (cmd.setup)
        begin
            a_reg        <= '0;
            b_reg        <= '0;
            ir_reg       <= ir0;
            ic_reg       <= ic0;
            row_base_reg <= ir0 * n_s;
            // kernel read backwards gives the 180 degree rotation
            kaddr_reg    <= KADDR_W'(kk - 8'd1);
            acc_reg      <= '0;
        end
        if (cmd.step)
        begin
            kaddr_reg <= kaddr_reg - KADDR_W'(1);
            if (row_end)
            begin
                b_reg        <= '0;
                a_reg        <= a_reg + KCNT_W'(1);
                ic_reg       <= ic0;
                ir_reg       <= ir_reg + 8'sd1;
                row_base_reg <= row_base_reg + 16'(n_s);
            end
            else
            begin
                b_reg  <= b_reg + KCNT_W'(1);
                ic_reg <= ic_reg + 8'sd1;
            end
        end
        inb1_reg <= inb;
        // zero border taps contribute nothing
        prod_reg <= inb1_reg ? coef_reg * pix_reg : 32'sd0;
        if (v2_reg)
        begin
            acc_reg <= acc_reg + 38'(prod_reg);
        end
        if (cmd.publish)
        begin
            if (bad_reg)
            begin
                out_data.conv_value   <= '0;
                out_data.out_row      <= '0;
                out_data.out_col      <= '0;
                out_data.last         <= 1'b0;
                out_data.bad_geometry <= 1'b1;
            end
            else
            begin
                out_data.conv_value   <= acc_reg;
                out_data.out_row      <= r_reg;
                out_data.out_col      <= c_reg;
                out_data.last         <= is_last;
                out_data.bad_geometry <= 1'b0;
            end
        end
    end

endmodule

### rtl/conv2d_zero_padded.sv
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  in_data (op, sample)
// out       output     out_valid/out_stall  out_data (conv_value, out_row, out_col, last,
//                                           bad_geometry)
// cfg       input      cfg_we               cfg_index, cfg_data
//
// loads are taken while idle; an emit walks the window with one
// multiply-accumulate per cycle and one image store read port
// a bad-geometry emit skips the window walk
// rst_n resets control, load indexes, cursors and configuration; the stores are not cleared
// the finished result sits in an output register, so loads keep flowing
// while out_stall holds it; a new emit waits only for that register
module conv2d_zero_padded
    import c2dzp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    c2dzp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_op     (in_data.op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    c2dzp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (in_data.sample),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

### tb/conv2d_zero_padded_tb.sv
`timescale 1ns / 1ps
module conv2d_zero_padded_tb;
    import c2dzp_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 600;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_kind_t;
    typedef enum logic [1:0] {FILL_RANDOM, FILL_MIN, FILL_MAX} fill_kind_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_item_t   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [6:0] cfg_data  = '0;

    // shadow copy of the block state
    logic [15:0] coef_mem [KDEPTH];
    bit          coef_set [KDEPTH];
    logic [15:0] pix_mem  [IDEPTH];
    bit          pix_set  [IDEPTH];
    int unsigned img_n = 32'(IMAGE_SIZE_RST);
    int unsigned ker_k = 32'(KERNEL_SIZE_RST);
    int unsigned pad_w = 32'(PAD_WIDTH_RST);
    int unsigned coef_idx = 0;
    int unsigned pix_idx  = 0;
    int unsigned cur_row  = 0;
    int unsigned cur_col  = 0;

    out_item_t   conv_due_q [$];
    int          fail_count = 0;
    int          items_sent = 0;

    bit          idle_on    = 1'b0;
    int unsigned burst_left = 0;
    bit          hold_req   = 1'b0;
    int unsigned hold_left  = 0;
    stall_kind_t stall_mode = STALL_NONE;
    int unsigned mode_left  = 0;
    fill_kind_t  fill_mode  = FILL_RANDOM;

    conv2d_zero_padded u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit geometry_bad();
        return img_n == 0 || img_n > MAX_IMAGE || ker_k == 0 || ker_k > MAX_KERNEL
            || img_n + 2 * pad_w < ker_k;
    endfunction

    function automatic int unsigned out_side();
        return img_n + 2 * pad_w - ker_k + 1;
    endfunction

    function automatic int unsigned wrap_next(int unsigned idx, int unsigned limit,
                                              int unsigned depth);
        return (idx + 1 >= limit || idx + 1 >= depth) ? 0 : idx + 1;
    endfunction

    function automatic bit window_inside(int unsigned pr, int unsigned pc);
        return pr >= pad_w && pc >= pad_w && pr - pad_w < img_n && pc - pad_w < img_n;
    endfunction

    // true when the next emit reads only entries loaded since reset
    function automatic bit emit_ready();
        int unsigned s, r, c, a, b;
        if (geometry_bad())
            return 1'b1;
        s = out_side();
        r = cur_row;
        c = cur_col;
        if (r >= s || c >= s)
        begin
            r = 0;
            c = 0;
        end
        for (a = 0; a < ker_k; a++)
        begin
            for (b = 0; b < ker_k; b++)
            begin
                if (window_inside(r + a, c + b))
                begin
                    if (!coef_set[(ker_k - 1 - a) * ker_k + (ker_k - 1 - b)]
                        || !pix_set[(r + a - pad_w) * img_n + (c + b - pad_w)])
                        return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_conv(in_item_t it);
        out_item_t          res;
        int unsigned        s, r, c, a, b;
        logic signed [15:0] coef, pix;
        longint             acc;
        case (it.op)
            OP_LOAD_KERNEL:
            begin
                coef_mem[coef_idx] = it.sample;
                coef_set[coef_idx] = 1'b1;
                coef_idx = wrap_next(coef_idx, ker_k * ker_k, KDEPTH);
            end
            OP_LOAD_PIXEL:
            begin
                pix_mem[pix_idx] = it.sample;
                pix_set[pix_idx] = 1'b1;
                pix_idx = wrap_next(pix_idx, img_n * img_n, IDEPTH);
            end
            OP_EMIT:
            begin
                res = '0;
                if (geometry_bad())
                begin
                    res.bad_geometry = 1'b1;
                end
                else
                begin
                    s = out_side();
                    if (cur_row >= s || cur_col >= s)
                    begin
                        cur_row = 0;
                        cur_col = 0;
                    end
                    r = cur_row;
                    c = cur_col;
                    acc = 0;
                    // kernel rotated by 180 degrees against the padded window
                    for (a = 0; a < ker_k; a++)
                    begin
                        for (b = 0; b < ker_k; b++)
                        begin
                            if (window_inside(r + a, c + b))
                            begin
                                coef = coef_mem[(ker_k - 1 - a) * ker_k + (ker_k - 1 - b)];
                                pix  = pix_mem[(r + a - pad_w) * img_n + (c + b - pad_w)];
                                acc += longint'(coef) * longint'(pix);
                            end
                        end
                    end
                    res.conv_value = acc[37:0];
                    res.out_row    = r[6:0];
                    res.out_col    = c[6:0];
                    res.last       = (r == s - 1) && (c == s - 1);
                    if (c + 1 < s)
                    begin
                        cur_col = c + 1;
                    end
                    else
                    begin
                        cur_col = 0;
                        cur_row = (r + 1 < s) ? r + 1 : 0;
                    end
                end
                conv_due_q.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        case (fill_mode)
            FILL_MIN: v = 16'h8000;
            FILL_MAX: v = 16'h7FFF;
            default:
            begin
                case ($urandom_range(0, 7))
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = 16'h0000;
                    default: v = 16'($urandom_range(0, 16'hFFFF));
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic void compare_field(string name, logic signed [63:0] want,
                                          logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // one input transaction; called and returning at a rising edge
    task automatic send_item(logic [1:0] op, logic [15:0] smp);
        in_item_t it;
        it.op     = op;
        it.sample = smp;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_conv(it);
        items_sent++;
        if (burst_left != 0)
        begin
            burst_left--;
        end
        else if (idle_on)
        begin
            burst_left = $urandom_range(0, 24);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (conv_due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [6:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_IMAGE_SIZE:  img_n = 32'(value);
            CFG_KERNEL_SIZE: ker_k = 32'(value[3:0]);
            CFG_PAD_WIDTH:   pad_w = 32'(value[2:0]);
            default: ;
        endcase
        if (idx != CFG_UNUSED)
        begin
            coef_idx = 0;
            pix_idx  = 0;
            cur_row  = 0;
            cur_col  = 0;
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // all three registers in random order, junk in the unused upper bits
    task automatic set_geometry(int unsigned n, int unsigned k, int unsigned p);
        logic [6:0]  kv, pv;
        int unsigned order, i;
        settle();
        kv = 7'($urandom_range(0, 127));
        kv[3:0] = k[3:0];
        pv = 7'($urandom_range(0, 127));
        pv[2:0] = p[2:0];
        order = $urandom_range(0, 2);
        for (i = 0; i < 3; i++)
        begin
            case ((order + i) % 3)
                0:       cfg_write(CFG_IMAGE_SIZE, n[6:0]);
                1:       cfg_write(CFG_KERNEL_SIZE, kv);
                default: cfg_write(CFG_PAD_WIDTH, pv);
            endcase
        end
    endtask

    task automatic load_kernel(int unsigned count);
        repeat (count) send_item(OP_LOAD_KERNEL, pick_sample());
    endtask

    task automatic load_pixels(int unsigned count);
        repeat (count) send_item(OP_LOAD_PIXEL, pick_sample());
    endtask

    // pixels are streamed in until the next window is fully loaded
    task automatic emit_when_ready();
        while (!emit_ready())
            send_item(OP_LOAD_PIXEL, pick_sample());
        send_item(OP_EMIT, 16'($urandom_range(0, 16'hFFFF)));
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0:       send_item(OP_UNUSED, 16'($urandom_range(0, 16'hFFFF)));
            1:       send_item(OP_LOAD_KERNEL, pick_sample());
            default: send_item(OP_LOAD_PIXEL, pick_sample());
        endcase
    endtask

    task automatic test_directed();
        set_geometry(2, 2, 1);
        idle_on = 1'b0;
        send_item(OP_LOAD_KERNEL, 16'h8000);
        send_item(OP_LOAD_KERNEL, 16'h7FFF);
        send_item(OP_LOAD_KERNEL, 16'h0000);
        send_item(OP_LOAD_KERNEL, 16'hFFFF);
        send_item(OP_LOAD_PIXEL, 16'h7FFF);
        send_item(OP_LOAD_PIXEL, 16'h8000);
        send_item(OP_LOAD_PIXEL, 16'h5555);
        send_item(OP_LOAD_PIXEL, 16'hAAAA);
        send_item(OP_UNUSED, 16'hFFFF);
        // 3x3 outputs, then the cursor wraps
        repeat (10) emit_when_ready();
    endtask

    task automatic test_bad_geometry();
        int unsigned shapes [6][3] = '{'{1, 4, 1}, '{0, 3, 0}, '{100, 3, 0},
                                       '{127, 2, 1}, '{5, 0, 0}, '{5, 12, 0}};
        int unsigned i;
        idle_on = 1'b1;
        for (i = 0; i < 6; i++)
        begin
            set_geometry(shapes[i][0], shapes[i][1], shapes[i][2]);
            send_item(OP_EMIT, 16'($urandom_range(0, 16'hFFFF)));
            send_item(OP_LOAD_KERNEL, pick_sample());
            send_item(OP_LOAD_PIXEL, pick_sample());
            send_item(OP_EMIT, 16'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    // a write to an index past the register list must leave the cursor alone
    task automatic test_config_unused();
        set_geometry(3, 2, 0);
        load_kernel(4);
        load_pixels(9);
        repeat (2) emit_when_ready();
        settle();
        cfg_write(CFG_UNUSED, 7'($urandom_range(0, 127)));
        repeat (3) emit_when_ready();
    endtask

    task automatic test_backpressure();
        set_geometry(4, 2, 0);
        load_kernel(4);
        load_pixels(16);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (9) emit_when_ready();
        load_pixels(3);
        // sender waits for every result before going on
        settle();
        repeat (4) emit_when_ready();
    endtask

    task automatic test_large_image();
        set_geometry(MAX_IMAGE, MAX_KERNEL, 7);
        idle_on = 1'b1;
        load_kernel(MAX_KERNEL * MAX_KERNEL);
        load_pixels(2 * MAX_IMAGE);
        // all of output row 0 and the start of row 1
        repeat (90) emit_when_ready();
    endtask

    task automatic test_random_images();
        int unsigned n, k, p, s, emits, target, kmax;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            n = $urandom_range(1, 6);
            p = $urandom_range(0, 3);
            kmax = (n + 2 * p < MAX_KERNEL) ? n + 2 * p : MAX_KERNEL;
            k = $urandom_range(1, kmax);
            case ($urandom_range(0, 9))
                0:
                begin
                    case ($urandom_range(0, 4))
                        0:       n = 0;
                        1:       n = $urandom_range(MAX_IMAGE + 1, 127);
                        2:       k = 0;
                        3:       k = $urandom_range(MAX_KERNEL + 1, 15);
                        default:
                        begin
                            n = $urandom_range(1, 3);
                            p = 0;
                            k = $urandom_range(n + 1, MAX_KERNEL);
                        end
                    endcase
                end
                1:
                begin
                    n = $urandom_range(9, 20);
                    p = $urandom_range(0, 7);
                    k = $urandom_range(1, MAX_KERNEL);
                end
                default: ;
            endcase
            case ($urandom_range(0, 7))
                0:       fill_mode = FILL_MIN;
                1:       fill_mode = FILL_MAX;
                default: fill_mode = FILL_RANDOM;
            endcase
            set_geometry(n, k, p);
            idle_on = ($urandom_range(0, 3) != 0);
            if (geometry_bad())
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_noise();
                    send_item(OP_EMIT, 16'($urandom_range(0, 16'hFFFF)));
                end
            end
            else
            begin
                load_kernel(ker_k * ker_k);
                load_pixels((img_n <= 8) ? img_n * img_n : 4 * img_n);
                s = out_side();
                emits = (s * s <= 64) ? s * s + $urandom_range(0, 3) : $urandom_range(20, 60);
                repeat (emits)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_noise();
                    emit_when_ready();
                end
            end
        end
        fill_mode = FILL_RANDOM;
    endtask

    // receiver stall pattern, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_kind_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(50, 300);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                STALL_TOGGLE: out_stall <= ~out_stall;
                default:      out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin : check_outputs
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (conv_due_q.size() == 0)
            begin
                $error("output transaction with nothing outstanding: row %0d col %0d",
                       out_data.out_row, out_data.out_col);
                fail_count++;
            end
            else
            begin
                want = conv_due_q.pop_front();
                compare_field("conv_value", want.conv_value, out_data.conv_value);
                compare_field("out_row", want.out_row, out_data.out_row);
                compare_field("out_col", want.out_col, out_data.out_col);
                compare_field("last", want.last, out_data.last);
                compare_field("bad_geometry", want.bad_geometry, out_data.bad_geometry);
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_bad_geometry();
        test_config_unused();
        test_backpressure();
        test_large_image();
        test_random_images();
        settle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // several times the slowest legal run
    initial
    begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
